// ----- rtl/bzr_pkg.sv -----
// Shared constants and types for the cubic Bezier point evaluator.
package bzr_pkg;

	// Control point coordinate width, integer pixels.
	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 8;
	// Width of a Q(COORD_BITS).8 value.
	localparam int VAL_W      = COORD_BITS + FRAC_BITS;

	// Curve parameter, Q1.16, 1.0 = 2**16.
	localparam int T_W        = 17;
	localparam int T_SHIFT    = 16;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_SHIFT;

	// Signed difference times signed-extended t.
	localparam int DIFF_W     = VAL_W + 1;
	localparam int PROD_W     = DIFF_W + T_W + 1;

	localparam int OUT_W      = 18;

	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_CTRL1_X = 3'd2,
		REG_CTRL1_Y = 3'd3,
		REG_CTRL2_X = 3'd4,
		REG_CTRL2_Y = 3'd5,
		REG_END_X   = 3'd6,
		REG_END_Y   = 3'd7
	} cfg_reg_t;

	localparam logic [COORD_BITS-1:0] RST_START_X = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] RST_START_Y = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_CTRL1_X = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] RST_CTRL1_Y = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] RST_CTRL2_X = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_CTRL2_Y = COORD_BITS'(200);
	localparam logic [COORD_BITS-1:0] RST_END_X   = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_END_Y   = COORD_BITS'(400);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} point_t;

	// The four control points, start to end.
	typedef struct packed {
		point_t start;
		point_t ctrl1;
		point_t ctrl2;
		point_t stop;
	} ctrl_pts_t;

endpackage

// ----- rtl/bzr_if.sv -----
// Handshake channels: curve parameter in, curve point out.
interface bzr_pos_if;
	logic                      valid;
	logic                      ready;
	logic [bzr_pkg::T_W-1:0]   position;

	modport source(output valid, output position, input ready);
	modport sink(input valid, input position, output ready);
endinterface

interface bzr_point_if;
	logic                      valid;
	logic                      ready;
	logic [bzr_pkg::OUT_W-1:0] point_x;
	logic [bzr_pkg::OUT_W-1:0] point_y;

	modport source(output valid, output point_x, output point_y, input ready);
	modport sink(input valid, input point_x, input point_y, output ready);
endinterface

// ----- rtl/cubic_bezier_point_eval_top.sv -----
// Top level: three-stage de Casteljau cubic Bezier point evaluator.
//
// Each item on position_ch carries a curve parameter t in Q1.16 (65536 = 1.0;
// anything larger is taken as 1.0) and yields one item on point_ch holding
// the curve point in Q10.8. The four control points live in eight registers
// (start, ctrl1, ctrl2, end; x then y) written through cfg_wr_en/cfg_index/
// cfg_data; write them only while no item is in flight. The datapath is a
// three-stage pipeline, one interpolation level per stage: stage 1 forms the
// three first-level lerps per axis, stage 2 the two second-level lerps,
// stage 3 the final point, which is also the output register. Each stage is
// one subtract, one multiply and one add per lerp (12 multipliers in all).
// Throughput is one item per clock while point_ch is ready. An accepted
// item moves through the stage 1, 2 and 3 registers and is offered on
// point_ch from stage 3. Backpressure on point_ch stalls the stages in place;
// empty stages keep accepting, so the pipe fills up to three items under stall.
module cubic_bezier_point_eval_top (
	input  logic                            clk,
	input  logic                            arst_n,
	bzr_pos_if.sink                         position_ch,
	bzr_point_if.source                     point_ch,
	input  logic                            cfg_wr_en,
	input  logic [bzr_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [bzr_pkg::COORD_BITS-1:0]  cfg_data
);

	localparam int AXES = 2;

	bzr_pkg::ctrl_pts_t pts;

	bzr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pts       (pts)
	);

	// ---- control points in Q.8, axis 0 = x, axis 1 = y
	logic [bzr_pkg::VAL_W-1:0] cp [AXES][4];

	always_comb begin
		cp[0][0] = bzr_pkg::VAL_W'(pts.start.x) << bzr_pkg::FRAC_BITS;
		cp[0][1] = bzr_pkg::VAL_W'(pts.ctrl1.x) << bzr_pkg::FRAC_BITS;
		cp[0][2] = bzr_pkg::VAL_W'(pts.ctrl2.x) << bzr_pkg::FRAC_BITS;
		cp[0][3] = bzr_pkg::VAL_W'(pts.stop.x)  << bzr_pkg::FRAC_BITS;
		cp[1][0] = bzr_pkg::VAL_W'(pts.start.y) << bzr_pkg::FRAC_BITS;
		cp[1][1] = bzr_pkg::VAL_W'(pts.ctrl1.y) << bzr_pkg::FRAC_BITS;
		cp[1][2] = bzr_pkg::VAL_W'(pts.ctrl2.y) << bzr_pkg::FRAC_BITS;
		cp[1][3] = bzr_pkg::VAL_W'(pts.stop.y)  << bzr_pkg::FRAC_BITS;
	end

	// ---- clamp t to 1.0: any value above 2**16 has bit 16 set
	logic [bzr_pkg::T_W-1:0] t_in;
	assign t_in = position_ch.position[bzr_pkg::T_SHIFT] ? bzr_pkg::T_ONE
	                                                     : position_ch.position;

	// ---- stage handshake: a stage takes new data when empty or when it drains
	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3 = !vld_s3 || point_ch.ready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign position_ch.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= position_ch.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// ---- datapath
	logic [bzr_pkg::VAL_W-1:0] l1_c [AXES][3];
	logic [bzr_pkg::VAL_W-1:0] l1_s1 [AXES][3];
	logic [bzr_pkg::T_W-1:0]   t_s1;
	logic [bzr_pkg::VAL_W-1:0] l2_c [AXES][2];
	logic [bzr_pkg::VAL_W-1:0] l2_s2 [AXES][2];
	logic [bzr_pkg::T_W-1:0]   t_s2;
	logic [bzr_pkg::VAL_W-1:0] l3_c [AXES];
	logic [bzr_pkg::VAL_W-1:0] l3_s3 [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		// level 1: start-ctrl1, ctrl1-ctrl2, ctrl2-end
		for (genvar i = 0; i < 3; i++) begin : g_l1
			bzr_lerp u_lerp (.p(cp[a][i]), .q(cp[a][i+1]), .t(t_in), .r(l1_c[a][i]));
		end
		// level 2
		for (genvar i = 0; i < 2; i++) begin : g_l2
			bzr_lerp u_lerp (.p(l1_s1[a][i]), .q(l1_s1[a][i+1]), .t(t_s1),
				.r(l2_c[a][i]));
		end
		// level 3: the curve point
		bzr_lerp u_l3 (.p(l2_s2[a][0]), .q(l2_s2[a][1]), .t(t_s2), .r(l3_c[a]));
	end

	// payload registers load only when their stage takes a valid item
	always_ff @(posedge clk) begin
		if (rdy_s1 && position_ch.valid) begin
			l1_s1 <= l1_c;
			t_s1  <= t_in;
		end
		if (rdy_s2 && vld_s1) begin
			l2_s2 <= l2_c;
			t_s2  <= t_s1;
		end
		if (rdy_s3 && vld_s2) begin
			l3_s3 <= l3_c;
		end
	end

	// stage 3 is the output register; width fits to the 18-bit fields
	assign point_ch.valid   = vld_s3;
	assign point_ch.point_x = bzr_pkg::OUT_W'(l3_s3[0]);
	assign point_ch.point_y = bzr_pkg::OUT_W'(l3_s3[1]);

endmodule

// ----- rtl/bzr_cfg_regs.sv -----
// Control point register file with write port.
module bzr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bzr_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [bzr_pkg::COORD_BITS-1:0]   cfg_data,
	output bzr_pkg::ctrl_pts_t               pts
);

	bzr_pkg::ctrl_pts_t pts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q.start.x <= bzr_pkg::RST_START_X;
			pts_q.start.y <= bzr_pkg::RST_START_Y;
			pts_q.ctrl1.x <= bzr_pkg::RST_CTRL1_X;
			pts_q.ctrl1.y <= bzr_pkg::RST_CTRL1_Y;
			pts_q.ctrl2.x <= bzr_pkg::RST_CTRL2_X;
			pts_q.ctrl2.y <= bzr_pkg::RST_CTRL2_Y;
			pts_q.stop.x  <= bzr_pkg::RST_END_X;
			pts_q.stop.y  <= bzr_pkg::RST_END_Y;
		end else if (cfg_wr_en) begin
			unique case (bzr_pkg::cfg_reg_t'(cfg_index))
				bzr_pkg::REG_START_X: pts_q.start.x <= cfg_data;
				bzr_pkg::REG_START_Y: pts_q.start.y <= cfg_data;
				bzr_pkg::REG_CTRL1_X: pts_q.ctrl1.x <= cfg_data;
				bzr_pkg::REG_CTRL1_Y: pts_q.ctrl1.y <= cfg_data;
				bzr_pkg::REG_CTRL2_X: pts_q.ctrl2.x <= cfg_data;
				bzr_pkg::REG_CTRL2_Y: pts_q.ctrl2.y <= cfg_data;
				bzr_pkg::REG_END_X:   pts_q.stop.x  <= cfg_data;
				bzr_pkg::REG_END_Y:   pts_q.stop.y  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pts = pts_q;

endmodule

// ----- rtl/bzr_lerp.sv -----
// One fixed-point linear interpolation: p + floor((q - p) * t / 2**16).
module bzr_lerp (
	input  logic [bzr_pkg::VAL_W-1:0] p,
	input  logic [bzr_pkg::VAL_W-1:0] q,
	input  logic [bzr_pkg::T_W-1:0]   t,
	output logic [bzr_pkg::VAL_W-1:0] r
);

	logic signed [bzr_pkg::DIFF_W-1:0] diff;
	logic signed [bzr_pkg::T_W:0]      t_s;
	logic signed [bzr_pkg::PROD_W-1:0] prod;
	logic signed [bzr_pkg::PROD_W-1:0] prod_sh;
	logic signed [bzr_pkg::DIFF_W-1:0] step;
	logic signed [bzr_pkg::DIFF_W-1:0] sum;

	always_comb begin
		diff    = $signed({1'b0, q}) - $signed({1'b0, p});
		t_s     = $signed({1'b0, t});
		prod    = diff * t_s;
		// arithmetic shift floors toward minus infinity
		prod_sh = prod >>> bzr_pkg::T_SHIFT;
		// |step| <= |diff| since t <= 1
		step    = prod_sh[bzr_pkg::DIFF_W-1:0];
		sum     = $signed({1'b0, p}) + step;
		r       = sum[bzr_pkg::VAL_W-1:0];
	end

endmodule

// ----- bench/bzr_point_checker.sv -----
// Checker: predicts each curve point from the accepted parameter and compares the results.
module bzr_point_checker
	import bzr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	bzr_pos_if                    pos_mon,
	bzr_point_if                  pt_mon,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
	} curve_point_t;

	curve_point_t expected_points[$];
	curve_point_t want;
	ctrl_pts_t    curve;
	int           err_cnt;

	// p + floor((q - p) * t / 2**16); arithmetic shift of a signed value floors
	function automatic longint lerp_q8(longint p, longint q, longint t);
		return p + (((q - p) * t) >>> T_SHIFT);
	endfunction

	function automatic logic [OUT_W-1:0] bezier_axis(logic [COORD_BITS-1:0] a,
			logic [COORD_BITS-1:0] b, logic [COORD_BITS-1:0] c,
			logic [COORD_BITS-1:0] d, longint t);
		longint qa, qb, qc, qd, l1, l2, l3, l4, l5;
		qa = longint'(a) * (64'sd1 << FRAC_BITS);
		qb = longint'(b) * (64'sd1 << FRAC_BITS);
		qc = longint'(c) * (64'sd1 << FRAC_BITS);
		qd = longint'(d) * (64'sd1 << FRAC_BITS);
		l1 = lerp_q8(qa, qb, t);
		l2 = lerp_q8(qb, qc, t);
		l3 = lerp_q8(qc, qd, t);
		l4 = lerp_q8(l1, l2, t);
		l5 = lerp_q8(l2, l3, t);
		return OUT_W'(lerp_q8(l4, l5, t));
	endfunction

	function automatic curve_point_t curve_point(ctrl_pts_t pts, logic [T_W-1:0] pos);
		curve_point_t r;
		longint t;
		t = (pos > T_ONE) ? longint'(T_ONE) : longint'(pos);
		r.x = bezier_axis(pts.start.x, pts.ctrl1.x, pts.ctrl2.x, pts.stop.x, t);
		r.y = bezier_axis(pts.start.y, pts.ctrl1.y, pts.ctrl2.y, pts.stop.y, t);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve.start.x = RST_START_X;
			curve.start.y = RST_START_Y;
			curve.ctrl1.x = RST_CTRL1_X;
			curve.ctrl1.y = RST_CTRL1_Y;
			curve.ctrl2.x = RST_CTRL2_X;
			curve.ctrl2.y = RST_CTRL2_Y;
			curve.stop.x  = RST_END_X;
			curve.stop.y  = RST_END_Y;
			expected_points.delete();
			err_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (pt_mon.valid && pt_mon.ready) begin
				if (expected_points.size() == 0) begin
					$display("%t: unexpected point: expected none, got x=%0d y=%0d",
						$time, pt_mon.point_x, pt_mon.point_y);
					err_cnt++;
				end else begin
					want = expected_points.pop_front();
					if (pt_mon.point_x !== want.x) begin
						$display("%t: point_x mismatch: expected %0d, got %0d",
							$time, want.x, pt_mon.point_x);
						err_cnt++;
					end
					if (pt_mon.point_y !== want.y) begin
						$display("%t: point_y mismatch: expected %0d, got %0d",
							$time, want.y, pt_mon.point_y);
						err_cnt++;
					end
				end
			end
			if (pos_mon.valid && pos_mon.ready)
				expected_points.push_back(curve_point(curve, pos_mon.position));
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_START_X: curve.start.x = cfg_data;
					REG_START_Y: curve.start.y = cfg_data;
					REG_CTRL1_X: curve.ctrl1.x = cfg_data;
					REG_CTRL1_Y: curve.ctrl1.y = cfg_data;
					REG_CTRL2_X: curve.ctrl2.x = cfg_data;
					REG_CTRL2_Y: curve.ctrl2.y = cfg_data;
					REG_END_X:   curve.stop.x  = cfg_data;
					REG_END_Y:   curve.stop.y  = cfg_data;
					default: ;
				endcase
			end
			errors  <= err_cnt;
			pending <= expected_points.size();
		end
	end

endmodule

// ----- bench/cubic_bezier_point_eval_top_tb.sv -----
// Testbench top: stimulus, receiver backpressure and verdict for the Bezier point evaluator.
module cubic_bezier_point_eval_top_tb
	import bzr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Pipe is three stages deep; spare idle cycles follow once every point is back.
	localparam int DRAIN_CYCLES = 6;
	// Watchdog limit, set with lots of room over the slowest legal run.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 80;
	// Receiver hold-off long enough to fill the pipe and back up the input.
	localparam int LONG_HOLD    = 150;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [COORD_BITS-1:0] cfg_data;

	int point_errors;
	int points_pending;
	int cycle_count;
	int stall_reqs;   // bumped by the stimulus to ask the receiver for a long hold-off
	int burst_left;
	bit gaps_on;

	bzr_pos_if   pos_ch();
	bzr_point_if pt_ch();

	cubic_bezier_point_eval_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.position_ch(pos_ch),
		.point_ch   (pt_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	bzr_point_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos_mon  (pos_ch),
		.pt_mon   (pt_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (point_errors),
		.pending  (points_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[cubic_bezier_point_eval_top] ERROR");
		$finish;
	end

	// Receiver: random ready modes, plus a long hold-off whenever the stimulus asks.
	initial begin
		int hold_cnt;
		int stall_seen;
		int mode;
		int mode_left;
		hold_cnt   = 0;
		stall_seen = 0;
		mode       = 0;
		mode_left  = 0;
		pt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				pt_ch.ready <= 1'b0;
			end else if (stall_seen != stall_reqs) begin
				stall_seen = stall_reqs;
				hold_cnt   = LONG_HOLD;
				pt_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0:       pt_ch.ready <= 1'b1;                      // no stalls
					1:       pt_ch.ready <= 1'($urandom_range(0, 1));  // coin flip
					2:       pt_ch.ready <= ($urandom_range(0, 9) != 0); // rare stalls
					default: pt_ch.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
				endcase
			end
		end
	end

	// One configuration register write; caller lowers cfg_wr_en after the last one
	// so that back-to-back writes keep the enable high without a glitch.
	task automatic write_reg(input cfg_reg_t r, input logic [COORD_BITS-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
	endtask

	task automatic load_curve(input ctrl_pts_t pts);
		write_reg(REG_START_X, pts.start.x);
		write_reg(REG_START_Y, pts.start.y);
		write_reg(REG_CTRL1_X, pts.ctrl1.x);
		write_reg(REG_CTRL1_Y, pts.ctrl1.y);
		write_reg(REG_CTRL2_X, pts.ctrl2.x);
		write_reg(REG_CTRL2_Y, pts.ctrl2.y);
		write_reg(REG_END_X,   pts.stop.x);
		write_reg(REG_END_Y,   pts.stop.y);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one item and wait for it to be taken; called at a clock edge.
	// In gap mode, bursts of random length are followed by idle stretches.
	task automatic offer_position(input logic [T_W-1:0] p);
		int gap;
		pos_ch.valid    <= 1'b1;
		pos_ch.position <= p;
		do @(posedge clk); while (!pos_ch.ready);
		if (gaps_on) begin
			if (burst_left > 0)
				burst_left--;
			else begin
				gap = $urandom_range(1, 8);
				pos_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 24);
			end
		end
	endtask

	// Sender goes quiet until every expected point is back. The first edge lets
	// the checker count an item taken at the current edge.
	task automatic drain_points();
		pos_ch.valid <= 1'b0;
		@(posedge clk);
		while (points_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly in-range t; some above 1.0 (saturates to the end point) and corners.
	function automatic logic [T_W-1:0] rand_position();
		case ($urandom_range(0, 9))
			0: return T_ONE + T_W'($urandom_range(1, 65535));
			1: begin
				case ($urandom_range(0, 5))
					0:       return '0;
					1:       return T_W'(1);
					2:       return T_ONE - 1'b1;
					3:       return T_ONE;
					4:       return T_ONE + 1'b1;
					default: return '1;
				endcase
			end
			default: return T_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Coordinates lean toward the rails so extreme differences show up often.
	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return COORD_MAX;
			default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
		endcase
	endfunction

	initial begin
		// Corner parameters: zero, tiny steps, halves, just under / at / over 1.0,
		// alternating bit patterns and the all-ones code.
		logic [T_W-1:0] corner_positions [16];
		ctrl_pts_t      pts;
		corner_positions = '{17'd0, 17'd1, 17'd2, 17'd255, 17'd256, 17'd16384,
			17'd32767, 17'd32768, 17'd49152, 17'd65535, 17'd65536, 17'd65537,
			17'h15555, 17'h0AAAA, 17'd98304, 17'h1FFFF};

		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_index       <= REG_START_X;
		cfg_data        <= '0;
		pos_ch.valid    <= 1'b0;
		pos_ch.position <= '0;
		stall_reqs      <= 0;
		burst_left      = 0;
		gaps_on         = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on the reset curve.
		foreach (corner_positions[i])
			offer_position(corner_positions[i]);
		drain_points();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: pts = '0;                       // degenerate curve at the origin
				1: pts = '1;                       // degenerate curve at the far corner
				2, 5: begin
					// Zig-zag between rails: largest positive and negative differences,
					// x and y in opposite sense.
					pts.start = '{x: '0,        y: COORD_MAX};
					pts.ctrl1 = '{x: COORD_MAX, y: '0};
					pts.ctrl2 = '{x: '0,        y: COORD_MAX};
					pts.stop  = '{x: COORD_MAX, y: '0};
				end
				default: begin
					pts.start = '{x: rand_coord(), y: rand_coord()};
					pts.ctrl1 = '{x: rand_coord(), y: rand_coord()};
					pts.ctrl2 = '{x: rand_coord(), y: rand_coord()};
					pts.stop  = '{x: rand_coord(), y: rand_coord()};
				end
			endcase
			load_curve(pts);

			// Back-pressure phases: receiver holds off while the sender streams with
			// no gaps, so the pipe fills and the input stalls.
			gaps_on = !(ph == 2 || ph == 5);
			if (!gaps_on)
				stall_reqs <= stall_reqs + 1;
			burst_left = $urandom_range(0, 24);

			repeat (PHASE_ITEMS)
				offer_position(rand_position());
			drain_points();
		end

		if (point_errors == 0 && points_pending == 0)
			$display("[cubic_bezier_point_eval_top] OK");
		else
			$display("[cubic_bezier_point_eval_top] ERROR");
		$finish;
	end

endmodule
